/* sv/lcw_pkg.sv */
// ----------------------------------------------------------------------------
// lcw_pkg
// Shared types and constants of the six-channel load-cell weigher.
// ----------------------------------------------------------------------------
package lcw_pkg;

  localparam int CHANNELS     = 6;
  localparam int SAMPLE_W     = 12;
  localparam int WEIGHT_W     = 20;
  localparam int TOTAL_W      = 22;
  localparam int ALPHA_W      = 9;
  localparam int GAIN_W       = 24;
  localparam int IN_DATA_W    = 72;
  localparam int OUT_DATA_W   = 168;
  localparam int OUT_PAD_W    = OUT_DATA_W - CHANNELS * WEIGHT_W - 2 * TOTAL_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;
  localparam int ROUND_SHIFT  = 24;
  localparam int GROUP_SIZE   = CHANNELS / 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd1197803;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [TOTAL_W-1:0]  total_t;

  localparam weight_t WEIGHT_MAX = '1;

  typedef struct packed {
    logic tare_add;
    logic div_load;
    logic ema_mul;
    logic ema_upd;
    logic weigh_diff;
    logic weigh_mul;
    logic weigh_sat;
  } lane_ctrl_t;

endpackage

/* sv/lcw_lane.sv */
// ----------------------------------------------------------------------------
// lcw_lane
// One channel: tare accumulation, tare average by reciprocal multiplication,
// moving average and scaling to grams with clamp and saturation.
// ----------------------------------------------------------------------------
module lcw_lane #(
  parameter int TARE_FRAMES = 10,
  parameter int ADC_BITS    = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lcw_pkg::lane_ctrl_t            ctrl,
  input  lcw_pkg::sample_t               sample,
  input  logic [lcw_pkg::ALPHA_W-1:0]    alpha,
  input  logic [lcw_pkg::GAIN_W-1:0]     gain,
  output lcw_pkg::weight_t               weight
);
  import lcw_pkg::*;

  localparam int SW     = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int LVL_W  = ADC_BITS + 8;
  localparam int RW     = $clog2(TARE_FRAMES + 1);
  localparam int SUM_W  = ADC_BITS + RW;
  localparam int NW     = SUM_W + 8;
  localparam int RSH    = NW + $clog2(TARE_FRAMES);
  localparam int MW     = NW + 2;
  localparam int QW     = NW + MW;
  localparam int PW     = LVL_W + ALPHA_W;
  localparam int GW     = LVL_W + GAIN_W;
  localparam int GMW    = GW + 1 - ROUND_SHIFT;
  localparam int EXT_W  = (GMW > WEIGHT_W) ? GMW : WEIGHT_W + 1;
  localparam logic [7:0]    HALF       = 8'(TARE_FRAMES / 2);
  localparam logic [63:0]   RECIP_FULL = ((64'd1 << RSH) / 64'(TARE_FRAMES)) + 64'd1;
  localparam logic [MW-1:0] RECIP      = MW'(RECIP_FULL);
  localparam logic [PW:0]  EMA_ROUND  = (PW + 1)'(128);
  localparam logic [GW:0]  GRAM_ROUND = (GW + 1)'(1) << (ROUND_SHIFT - 1);

  logic [SUM_W-1:0]   tare_sum;
  logic [LVL_W-1:0]   tare_q8;
  logic [LVL_W-1:0]   level;
  logic [PW-1:0]      p_new;
  logic [PW-1:0]      p_old;
  logic [LVL_W-1:0]   diff;
  logic               pos;
  logic [GW-1:0]      prod;

  logic [LVL_W-1:0]   x_q8;
  logic [ALPHA_W-1:0] keep;
  logic [NW-1:0]      dividend;
  logic [QW-1:0]      tare_prod;
  logic [PW:0]        ema_sum;
  logic [LVL_W-1:0]   level_next;
  logic [GW:0]        rounded;
  logic [EXT_W-1:0]   grams;
  weight_t            weight_next;

  always_comb begin
    x_q8       = LVL_W'({sample[SW-1:0], 8'b0});
    keep       = ALPHA_ONE - alpha;
    dividend   = {tare_sum, HALF};
    tare_prod  = QW'(dividend) * QW'(RECIP);
    ema_sum    = {1'b0, p_new} + {1'b0, p_old} + EMA_ROUND;
    level_next = ema_sum[LVL_W+7:8];
    rounded    = {1'b0, prod} + GRAM_ROUND;
    grams      = EXT_W'(rounded[GW:ROUND_SHIFT]);
    if (!pos) begin
      weight_next = '0;
    end else if (grams > EXT_W'(WEIGHT_MAX)) begin
      weight_next = WEIGHT_MAX;
    end else begin
      weight_next = grams[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tare_sum <= '0;
      level    <= '0;
    end else begin
      if (ctrl.tare_add) begin
        tare_sum <= tare_sum + SUM_W'(sample[SW-1:0]);
      end
      if (ctrl.ema_upd) begin
        level <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      tare_q8 <= tare_prod[RSH +: LVL_W];
    end
    if (ctrl.ema_mul) begin
      p_new <= PW'(alpha) * PW'(x_q8);
      p_old <= PW'(keep) * PW'(level);
    end
    if (ctrl.weigh_diff) begin
      diff <= level - tare_q8;
      pos  <= (level > tare_q8);
    end
    if (ctrl.weigh_mul) begin
      prod <= GW'(diff) * GW'(gain);
    end
    if (ctrl.weigh_sat) begin
      weight <= weight_next;
    end
  end

endmodule

/* sv/lcw_merge.sv */
// ----------------------------------------------------------------------------
// lcw_merge
// Group totals and the output register of the result stream.
// ----------------------------------------------------------------------------
module lcw_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  lcw_pkg::weight_t [lcw_pkg::CHANNELS-1:0] weights,
  input  logic                                  m_tready,
  output logic                                  m_tvalid,
  output logic [lcw_pkg::OUT_DATA_W-1:0]        m_tdata
);
  import lcw_pkg::*;

  total_t total_a;
  total_t total_b;

  always_comb begin
    total_a = '0;
    total_b = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      total_a = total_a + TOTAL_W'(weights[i]);
      total_b = total_b + TOTAL_W'(weights[GROUP_SIZE + i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, total_b, total_a, weights};
    end
  end

endmodule

/* sv/six_channel_load_cell_weigher_top.sv */
// ----------------------------------------------------------------------------
// six_channel_load_cell_weigher_top
// Six-channel load-cell weigher with tare and exponential smoothing.
// ----------------------------------------------------------------------------
// Each input transfer carries six ADC samples; six lanes process them side by
// side and a merge stage forms the group totals and holds the result. The
// first TARE_FRAMES frames after reset are summed and give no result; the
// frame that completes the tare is followed by a step in which every lane
// forms its rounded tare average by a reciprocal multiplication. Each later
// frame is multiplied, then goes through average update, tare subtract, gain
// multiply, round and saturate and load into the output register; the next
// frame is taken only after that load, also while the result waits there.
// The block stalls only when the next result finds the output register full.
// ----------------------------------------------------------------------------
module six_channel_load_cell_weigher_top #(
  parameter int TARE_FRAMES = 10,
  parameter int ADC_BITS    = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample_0, sample_1, sample_2, sample_3, sample_4, sample_5
  input  logic [lcw_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // weight_0 .. weight_5, group_a_total, group_b_total, zero fill
  output logic [lcw_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_we,
  input  logic [lcw_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [lcw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lcw_pkg::*;

  localparam int TCNT_W = $clog2(TARE_FRAMES + 1);
  localparam logic [TCNT_W-1:0] TARE_LAST = TCNT_W'(TARE_FRAMES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_UPD,
    ST_DIFF,
    ST_GMUL,
    ST_SAT,
    ST_MERGE
  } state_t;

  state_t                      state;
  logic [TCNT_W-1:0]           tare_cnt;
  logic [ALPHA_W-1:0]          alpha_q8;
  logic [GAIN_W-1:0]           gain_q16;
  logic [ALPHA_W-1:0]          alpha_eff;
  logic                        accept;
  logic                        tare_done;
  logic                        merge_load;
  lane_ctrl_t                  ctrl;
  weight_t [CHANNELS-1:0]      weights;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q8 <= ALPHA_RESET;
      gain_q16 <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ALPHA: alpha_q8 <= cfg_wdata[ALPHA_W-1:0];
        REG_GAIN:  gain_q16 <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_eff  = alpha_q8[ALPHA_W-1] ? ALPHA_ONE : alpha_q8;
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign tare_done  = (tare_cnt == TARE_LAST);
  assign merge_load = (state == ST_MERGE) && (!m_tvalid || m_tready);

  always_comb begin
    ctrl            = '0;
    ctrl.tare_add   = accept && !tare_done;
    ctrl.ema_mul    = accept && tare_done;
    ctrl.div_load   = (state == ST_DIV_LOAD);
    ctrl.ema_upd    = (state == ST_UPD);
    ctrl.weigh_diff = (state == ST_DIFF);
    ctrl.weigh_mul  = (state == ST_GMUL);
    ctrl.weigh_sat  = (state == ST_SAT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tare_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (tare_done) begin
              state <= ST_UPD;
            end else begin
              tare_cnt <= tare_cnt + 1'b1;
              if (tare_cnt + 1'b1 == TARE_LAST) begin
                state <= ST_DIV_LOAD;
              end
            end
          end
        end
        ST_DIV_LOAD: state <= ST_IDLE;
        ST_UPD:  state <= ST_DIFF;
        ST_DIFF: state <= ST_GMUL;
        ST_GMUL: state <= ST_SAT;
        ST_SAT:  state <= ST_MERGE;
        ST_MERGE: begin
          if (merge_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    lcw_lane #(
      .TARE_FRAMES (TARE_FRAMES),
      .ADC_BITS    (ADC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (s_tdata[c*SAMPLE_W +: SAMPLE_W]),
      .alpha  (alpha_eff),
      .gain   (gain_q16),
      .weight (weights[c])
    );
  end

  lcw_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (merge_load),
    .weights  (weights),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  a_tare_cnt_range: assert property (@(posedge clk) disable iff (rst)
    tare_cnt <= TARE_LAST)
    else $error("tare frame count past its end");

  a_result_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_MERGE))
    else $error("result raised outside the merge step");

  a_tare_frame_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !tare_done) |=> (state == ST_IDLE || state == ST_DIV_LOAD))
    else $error("tare frame started a measurement");

endmodule
